[design/lc3x_pkg.sv]
`timescale 1ns / 1ps

package lc3x_pkg;

  localparam int unsigned AddrBitsDefault = 16;
  localparam logic [15:0] StartPcReset = 16'h3000;

  localparam logic [2:0] FlagN = 3'b100;
  localparam logic [2:0] FlagZ = 3'b010;
  localparam logic [2:0] FlagP = 3'b001;

  localparam logic       CmdExec = 1'b0;
  localparam logic       CmdLoad = 1'b1;
  localparam logic [2:0] LinkReg = 3'd7;
  localparam logic       RegIdxStartPc = 1'b0;

  typedef enum logic [3:0] {
    OP_BR   = 4'h0,
    OP_ADD  = 4'h1,
    OP_LD   = 4'h2,
    OP_ST   = 4'h3,
    OP_JSR  = 4'h4,
    OP_AND  = 4'h5,
    OP_LDR  = 4'h6,
    OP_STR  = 4'h7,
    OP_RTI  = 4'h8,
    OP_NOT  = 4'h9,
    OP_LDI  = 4'hA,
    OP_STI  = 4'hB,
    OP_JMP  = 4'hC,
    OP_RES  = 4'hD,
    OP_LEA  = 4'hE,
    OP_TRAP = 4'hF
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MEM1,
    S_MEM2
  } seq_state_t;

  typedef struct packed {
    logic        command;
    logic [15:0] instruction;
    logic [15:0] load_address;
    logic [15:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic [2:0]  cond_flags;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
    logic        unsupported;
  } out_item_t;

  // main memory access, one per cycle
  typedef struct packed {
    logic        en;
    logic        we;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

  // register file write
  typedef struct packed {
    logic        we;
    logic [2:0]  idx;
    logic [15:0] data;
  } rf_wr_t;

  function automatic logic [15:0] sext5(input logic [15:0] ins);
    return {{11{ins[4]}}, ins[4:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] ins);
    return {{10{ins[5]}}, ins[5:0]};
  endfunction

  function automatic logic [15:0] sext9(input logic [15:0] ins);
    return {{7{ins[8]}}, ins[8:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] ins);
    return {{5{ins[10]}}, ins[10:0]};
  endfunction

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'd0) begin
      f = FlagZ;
    end else if (v[15]) begin
      f = FlagN;
    end else begin
      f = FlagP;
    end
    return f;
  endfunction

endpackage

[design/lc3x_mem.sv]
`timescale 1ns / 1ps

module lc3x_mem import lc3x_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  localparam int unsigned Depth = 2 ** ADDR_BITS;

  logic [15:0] mem [Depth];
  logic [15:0] rdata_r;

  // single port; read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr[ADDR_BITS-1:0]];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[design/lc3x_regfile.sv]
`timescale 1ns / 1ps

module lc3x_regfile import lc3x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [2:0]  raddr_a,
  input  logic [2:0]  raddr_b,
  output logic [15:0] rdata_a,
  output logic [15:0] rdata_b,
  input  rf_wr_t      wr
);

  logic [15:0] regs [8];
  logic [7:0]  valid_r;
  logic [15:0] rdata_a_r;
  logic [15:0] rdata_b_r;

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.we) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rdata_a_r <= valid_r[raddr_a] ? regs[raddr_a] : 16'd0;
      rdata_b_r <= valid_r[raddr_b] ? regs[raddr_b] : 16'd0;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[design/lc3_instruction_execute.sv]
// Channel  Ports                                                  Carries
// in       in_valid, in_stall, in_data                            one request: instruction or load
// out      out_valid, out_stall, out_data                         one result per request
// config   psel, penable, pwrite, paddr, pwdata, prdata, pready   start_pc at byte address 0
//
// ALU ops, BR, JMP, JSR, LEA, ST, STR and loads finish in S_EXEC; LD, LDR and STI go on
// through S_MEM1, and LDI through S_MEM1 and S_MEM2, as the single-port main memory serves
// one access at a time. A request arriving at an idle block first passes the input register.
// Reset: synchronous, active low; registers read zero, PC 0x3000, flags Z; memory not cleared.
// Stalls: a finished result waits in the output register while one more request enters the input
// register; the item under execution may read memory but finishes only once the result leaves.
`timescale 1ns / 1ps

module lc3_instruction_execute import lc3x_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // memory index mask, upper address bits are dropped
  localparam logic [15:0] AddrMask = 16'((32'd1 << ADDR_BITS) - 32'd1);

  // configuration
  logic [15:0] start_pc_r;

  // input register
  in_item_t    buf_r;
  logic        buf_valid_r;
  opcode_t     buf_op;

  // item under execution
  in_item_t    cur_r;
  seq_state_t  state_r, state_nxt;
  logic [15:0] pc_r;
  logic [2:0]  cond_r;

  // output register
  out_item_t   out_r;
  logic        out_valid_r;
  logic        out_free;

  // register file and its forwarding
  logic [2:0]  rf_raddr_a, rf_raddr_b;
  logic [15:0] rf_rdata_a, rf_rdata_b;
  logic        fwd_a_r, fwd_b_r;
  logic [15:0] fwd_val_r;
  rf_wr_t      rf_wr;
  logic [15:0] op_a, op_b;

  // main memory
  mem_req_t    mem_req;
  logic [15:0] mem_rdata;

  // decode / execute
  opcode_t     op;
  logic [2:0]  dr;
  logic [15:0] pc_inc, pc_rel, base_rel, alu_b;
  logic        fin, finish, take;
  logic        rd_req;
  logic [15:0] rd_addr;
  logic        rw, mw, unsup;
  logic [2:0]  ridx;
  logic [15:0] rval, maddr, mval, pc_new;
  logic [2:0]  cond_new;
  seq_state_t  step_nxt;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxStartPc) ? {16'd0, start_pc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= StartPcReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegIdxStartPc)) begin
      start_pc_r <= pwdata[15:0];
    end
  end

  // ---------------- input register ----------------
  assign buf_op   = opcode_t'(buf_r.instruction[15:12]);
  assign in_stall = buf_valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      buf_valid_r <= 1'b1;
    end else if (take) begin
      buf_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      buf_r <= in_data;
    end
  end

  // operands are read as the item moves into execution
  always_comb begin
    rf_raddr_a = buf_r.instruction[8:6];
    if (buf_op inside {OP_ST, OP_STI, OP_STR}) begin
      rf_raddr_b = buf_r.instruction[11:9];
    end else begin
      rf_raddr_b = buf_r.instruction[2:0];
    end
  end

  lc3x_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (take),
    .raddr_a (rf_raddr_a),
    .raddr_b (rf_raddr_b),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b),
    .wr      (rf_wr)
  );

  // a write in the same cycle as the operand read is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else if (take) begin
      fwd_a_r <= rf_wr.we && (rf_wr.idx == rf_raddr_a);
      fwd_b_r <= rf_wr.we && (rf_wr.idx == rf_raddr_b);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fwd_val_r <= rf_wr.data;
    end
  end

  assign op_a = fwd_a_r ? fwd_val_r : rf_rdata_a;
  assign op_b = fwd_b_r ? fwd_val_r : rf_rdata_b;

  // ---------------- execution ----------------
  assign op       = opcode_t'(cur_r.instruction[15:12]);
  assign dr       = cur_r.instruction[11:9];
  assign pc_inc   = pc_r + 16'd1;
  assign pc_rel   = pc_inc + sext9(cur_r.instruction);
  assign base_rel = op_a + sext6(cur_r.instruction);
  assign alu_b    = cur_r.instruction[5] ? sext5(cur_r.instruction) : op_b;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    fin      = 1'b0;
    rd_req   = 1'b0;
    rd_addr  = pc_rel;
    rw       = 1'b0;
    mw       = 1'b0;
    unsup    = 1'b0;
    ridx     = 3'd0;
    rval     = 16'd0;
    maddr    = 16'd0;
    mval     = 16'd0;
    pc_new   = pc_inc;
    step_nxt = state_r;
    case (state_r)
      S_EXEC: begin
        if (cur_r.command == CmdLoad) begin
          fin    = 1'b1;
          mw     = 1'b1;
          maddr  = cur_r.load_address & AddrMask;
          mval   = cur_r.load_data;
          pc_new = pc_r;
        end else begin
          case (op)
            OP_ADD: begin
              fin = 1'b1; rw = 1'b1; ridx = dr; rval = op_a + alu_b;
            end
            OP_AND: begin
              fin = 1'b1; rw = 1'b1; ridx = dr; rval = op_a & alu_b;
            end
            OP_NOT: begin
              fin = 1'b1; rw = 1'b1; ridx = dr; rval = ~op_a;
            end
            OP_LEA: begin
              fin = 1'b1; rw = 1'b1; ridx = dr; rval = pc_rel;
            end
            OP_BR: begin
              fin = 1'b1;
              if ((dr & cond_r) != 3'd0) begin
                pc_new = pc_rel;
              end
            end
            OP_JMP: begin
              fin = 1'b1; pc_new = op_a;
            end
            OP_JSR: begin
              fin = 1'b1; rw = 1'b1; ridx = LinkReg; rval = pc_inc;
              pc_new = cur_r.instruction[11] ? (pc_inc + sext11(cur_r.instruction)) : op_a;
            end
            OP_LD, OP_LDI, OP_STI: begin
              rd_req = 1'b1; rd_addr = pc_rel; step_nxt = S_MEM1;
            end
            OP_LDR: begin
              rd_req = 1'b1; rd_addr = base_rel; step_nxt = S_MEM1;
            end
            OP_ST: begin
              fin = 1'b1; mw = 1'b1; maddr = pc_rel & AddrMask; mval = op_b;
            end
            OP_STR: begin
              fin = 1'b1; mw = 1'b1; maddr = base_rel & AddrMask; mval = op_b;
            end
            default: begin
              // RTI, TRAP, reserved
              fin = 1'b1; unsup = 1'b1;
            end
          endcase
        end
      end
      S_MEM1: begin
        case (op)
          OP_LDI: begin
            rd_req = 1'b1; rd_addr = mem_rdata; step_nxt = S_MEM2;
          end
          OP_STI: begin
            fin = 1'b1; mw = 1'b1; maddr = mem_rdata & AddrMask; mval = op_b;
          end
          default: begin
            // LD, LDR
            fin = 1'b1; rw = 1'b1; ridx = dr; rval = mem_rdata;
          end
        endcase
      end
      S_MEM2: begin
        fin = 1'b1; rw = 1'b1; ridx = dr; rval = mem_rdata;
      end
      default: ;
    endcase

    cond_new = (rw && (op != OP_JSR)) ? flags_of(rval) : cond_r;
  end

  // register and memory writes happen only when the result can be registered
  assign finish = fin && out_free;
  assign take   = buf_valid_r && ((state_r == S_IDLE) || finish);

  always_comb begin
    if (take) begin
      state_nxt = S_EXEC;
    end else if (finish) begin
      state_nxt = S_IDLE;
    end else begin
      state_nxt = step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= buf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= StartPcReset;
      cond_r <= FlagZ;
    end else if (finish) begin
      pc_r   <= pc_new;
      cond_r <= cond_new;
    end
  end

  assign rf_wr.we   = finish && rw;
  assign rf_wr.idx  = ridx;
  assign rf_wr.data = rval;

  assign mem_req.en    = (finish && mw) || rd_req;
  assign mem_req.we    = mw;
  assign mem_req.addr  = mw ? maddr : rd_addr;
  assign mem_req.wdata = mval;

  lc3x_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_r.program_counter <= pc_new;
      out_r.cond_flags      <= cond_new;
      out_r.reg_written     <= rw;
      out_r.reg_index       <= ridx;
      out_r.reg_value       <= rval;
      out_r.mem_written     <= mw;
      out_r.mem_address     <= maddr;
      out_r.mem_value       <= mval;
      out_r.unsupported     <= unsup;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/lc3x_checker.sv]
`timescale 1ns / 1ps

module lc3x_checker import lc3x_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // no register write means zero index and value
  a_reg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_written |->
      out_data.reg_index == 3'd0 && out_data.reg_value == 16'd0)
    else $error("stale register fields");

  // unsupported opcodes, stores and program loads leave the register file alone
  a_no_reg_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.unsupported || out_data.mem_written) |->
      !out_data.reg_written && !(out_data.unsupported && out_data.mem_written))
    else $error("conflicting side effects");

endmodule

bind lc3_instruction_execute lc3x_checker u_chk (.*);

[dv/lc3_instruction_execute_tb.sv]
`timescale 1ns / 1ps

module lc3_instruction_execute_tb;
  import lc3x_pkg::*;

  // Memory geometry follows the block's default build.
  localparam int unsigned AW = AddrBitsDefault;
  localparam int unsigned MEM_WORDS = 1 << AW;
  localparam logic [15:0] MEM_MASK = 16'(MEM_WORDS - 1);

  // Generous ceiling: the run stays far below it even with both sides idling heavily.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // the loads that define memory before reads add roughly a quarter on top
  localparam int unsigned RANDOM_PER_PHASE = 320;
  localparam logic [2:0] START_PC_ADDR = {RegIdxStartPc, 2'b00};

  logic        clk;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lc3_instruction_execute #(
    .ADDR_BITS(AW)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Architectural mirror: register file, PC, NZP, memory and start_pc.
  // mem_set tracks which words hold a defined value; reads of anything else
  // are never generated.
  // ---------------------------------------------------------------------------
  logic [15:0] gpr [0:7];
  logic [15:0] pc_q;
  logic [2:0]  nzp_q;
  logic [15:0] start_pc_q;
  logic [15:0] mem_q [0:MEM_WORDS-1];
  bit          mem_set [0:MEM_WORDS-1];

  // Requests waiting for the driver, and the results they will produce, in
  // request order. Results are computed when the request is generated, since
  // requests are accepted strictly in that order.
  in_item_t    pending_reqs[$];
  out_item_t   due_results[$];

  int unsigned n_issued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sx(input logic [15:0] v, input int unsigned nb);
    logic [15:0] hi;
    hi = 16'hFFFF << nb;
    return v[nb-1] ? (v | hi) : (v & ~hi);
  endfunction

  function automatic logic [2:0] nzp_of(input logic [15:0] v);
    if (v == 16'd0) begin
      return FlagZ;
    end
    return v[15] ? FlagN : FlagP;
  endfunction

  function automatic logic [15:0] mem_word(input logic [15:0] a);
    return mem_q[a & MEM_MASK];
  endfunction

  // Applies one request to the mirror and returns the result it must produce.
  // PC is bumped first, so every PC-relative address uses PC+1.
  function automatic out_item_t execute_request(input in_item_t r);
    out_item_t   o;
    opcode_t     op;
    logic [15:0] ins;
    logic [15:0] pc1;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] ea;
    logic [2:0]  dr;
    logic [2:0]  sr1;
    o = '0;
    ins = r.instruction;
    op = opcode_t'(ins[15:12]);
    dr = ins[11:9];
    sr1 = ins[8:6];
    if (r.command == CmdLoad) begin
      // program load: only memory changes, instruction word is ignored
      ea = r.load_address & MEM_MASK;
      mem_q[ea] = r.load_data;
      mem_set[ea] = 1'b1;
      o.mem_written = 1'b1;
      o.mem_address = ea;
      o.mem_value = r.load_data;
    end else begin
      pc_q = pc_q + 16'd1;
      pc1 = pc_q;
      case (op)
        OP_ADD, OP_AND: begin
          b = ins[5] ? sx(ins, 5) : gpr[ins[2:0]];
          a = gpr[sr1];
          o.reg_value = (op == OP_ADD) ? a + b : a & b;
          o.reg_written = 1'b1;
          o.reg_index = dr;
        end
        OP_NOT: begin
          o.reg_value = ~gpr[sr1];
          o.reg_written = 1'b1;
          o.reg_index = dr;
        end
        OP_BR: begin
          if ((dr & nzp_q) != 3'd0) begin
            pc_q = pc1 + sx(ins, 9);
          end
        end
        OP_JMP: pc_q = gpr[sr1];
        OP_JSR: begin
          // JSRR R7 jumps to R7's old value; the link write comes after
          pc_q = ins[11] ? pc1 + sx(ins, 11) : gpr[sr1];
          o.reg_value = pc1;
          o.reg_written = 1'b1;
          o.reg_index = LinkReg;
        end
        OP_LD, OP_LDI: begin
          ea = pc1 + sx(ins, 9);
          if (op == OP_LDI) begin
            ea = mem_word(ea);
          end
          o.reg_value = mem_word(ea);
          o.reg_written = 1'b1;
          o.reg_index = dr;
        end
        OP_LDR: begin
          o.reg_value = mem_word(gpr[sr1] + sx(ins, 6));
          o.reg_written = 1'b1;
          o.reg_index = dr;
        end
        OP_LEA: begin
          o.reg_value = pc1 + sx(ins, 9);
          o.reg_written = 1'b1;
          o.reg_index = dr;
        end
        OP_ST, OP_STI, OP_STR: begin
          ea = (op == OP_STR) ? gpr[sr1] + sx(ins, 6) : pc1 + sx(ins, 9);
          if (op == OP_STI) begin
            ea = mem_word(ea);
          end
          ea = ea & MEM_MASK;
          mem_q[ea] = gpr[dr];
          mem_set[ea] = 1'b1;
          o.mem_written = 1'b1;
          o.mem_address = ea;
          o.mem_value = gpr[dr];
        end
        default: o.unsupported = 1'b1;  // RTI, reserved, TRAP
      endcase
      if (o.reg_written) begin
        gpr[o.reg_index] = o.reg_value;
        // JSR/JSRR leave the flags alone; LEA sets them
        if (op != OP_JSR) begin
          nzp_q = nzp_of(o.reg_value);
        end
      end
    end
    o.program_counter = pc_q;
    o.cond_flags = nzp_q;
    return o;
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %h, want %h", n_checked, name, got, want));
    end
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    check_field("program_counter", got.program_counter, want.program_counter);
    check_field("cond_flags", 16'(got.cond_flags), 16'(want.cond_flags));
    check_field("reg_written", 16'(got.reg_written), 16'(want.reg_written));
    check_field("reg_index", 16'(got.reg_index), 16'(want.reg_index));
    check_field("reg_value", got.reg_value, want.reg_value);
    check_field("mem_written", 16'(got.mem_written), 16'(want.mem_written));
    check_field("mem_address", got.mem_address, want.mem_address);
    check_field("mem_value", got.mem_value, want.mem_value);
    check_field("unsupported", 16'(got.unsupported), 16'(want.unsupported));
  endtask

  task automatic issue(input in_item_t r);
    due_results.push_back(execute_request(r));
    pending_reqs.push_back(r);
    n_issued++;
  endtask

  // Makes sure a word is defined before something reads it: if not, a
  // program-load request with random data goes out first.
  task automatic ensure_written(input logic [15:0] a);
    in_item_t w;
    if (!mem_set[a & MEM_MASK]) begin
      w.command = CmdLoad;
      w.instruction = 16'($urandom);
      w.load_address = a;
      w.load_data = 16'($urandom);
      issue(w);
    end
  endtask

  // Sends one request, preceded by whatever loads its memory reads need.
  task automatic send_request(input in_item_t r);
    logic [15:0] ins;
    logic [15:0] ea;
    ins = r.instruction;
    if (r.command == CmdExec) begin
      case (opcode_t'(ins[15:12]))
        OP_LD, OP_STI: ensure_written(pc_q + 16'd1 + sx(ins, 9));
        OP_LDI: begin
          ea = pc_q + 16'd1 + sx(ins, 9);
          ensure_written(ea);
          ensure_written(mem_word(ea));
        end
        OP_LDR: ensure_written(gpr[ins[8:6]] + sx(ins, 6));
        default: ;
      endcase
    end
    issue(r);
  endtask

  task automatic send_exec(input logic [15:0] ins);
    in_item_t r;
    r.command = CmdExec;
    r.instruction = ins;
    r.load_address = 16'($urandom);  // don't-care fields carry noise
    r.load_data = 16'($urandom);
    send_request(r);
  endtask

  task automatic send_load(input logic [15:0] a, input logic [15:0] d);
    in_item_t r;
    r.command = CmdLoad;
    r.instruction = 16'($urandom);
    r.load_address = a;
    r.load_data = d;
    send_request(r);
  endtask

  // Random traffic: mostly instructions over all sixteen opcodes, about one
  // in eight a program load to a random address.
  task automatic random_request();
    in_item_t r;
    r.command = ($urandom_range(7) == 0) ? CmdLoad : CmdExec;
    r.instruction = 16'($urandom);
    r.load_address = 16'($urandom);
    r.load_data = 16'($urandom);
    send_request(r);
  endtask

  task automatic wait_drained();
    while (n_checked < n_issued) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // APB: setup cycle, then access until pready.
  task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read(input logic [2:0] a, output logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // start_pc does not feed the PC, which resets to StartPcReset, and reset happens once;
  // the write is checked by reading it back.
  task automatic set_start_pc(input logic [15:0] v);
    logic [31:0] rd;
    cfg_write(START_PC_ADDR, {16'd0, v});
    start_pc_q = v;
    cfg_read(START_PC_ADDR, rd);
    if (rd[15:0] !== start_pc_q) begin
      report_error($sformatf("start_pc readback %h, want %h", rd[15:0], start_pc_q));
    end
  endtask

  task automatic run_phase(input int unsigned snd, input int unsigned rcv,
                           input logic [15:0] spc);
    set_start_pc(spc);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    repeat (RANDOM_PER_PHASE) random_request();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next request, holds it steady while stalled, and
  // inserts idle cycles at the phase's rate.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest outstanding one.
  // n_accepted is updated with a nonblocking write, so a result is only
  // matched to requests accepted at earlier edges.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (n_checked >= n_accepted) begin
          report_error($sformatf("result with no request outstanding, pc %h",
                                 out_data.program_counter));
        end else begin
          compare_result(out_data, due_results.pop_front());
          n_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_cnt, n_checked, n_issued);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // mirror reset state
    for (int i = 0; i < 8; i++) begin
      gpr[i] = 16'd0;
    end
    start_pc_q = StartPcReset;
    pc_q = start_pc_q;
    nzp_q = FlagZ;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, back to back ----------------------------------------------
    set_start_pc(16'hFFFF);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    send_load(16'h0000, 16'h8000);  // lowest address
    send_load(16'hFFFF, 16'h7FFF);  // highest address
    send_exec(16'h122F);            // ADD R1, R0, #15
    send_exec(16'h1430);            // ADD R2, R0, #-16
    send_exec(16'h5642);            // AND R3, R1, R2 -> zero
    send_exec(16'h98FF);            // NOT R4, R3 -> all ones
    send_exec(16'h1B04);            // ADD R5, R4, R4
    send_exec(16'h5AFF);            // AND R5, R3, #-1
    send_exec(16'hEC00);            // LEA R6, #0 sets flags
    send_exec(16'h0F00);            // BRnzp, offset -256
    send_exec(16'h00FF);            // BR with no condition: never taken
    send_exec(16'hC100);            // JMP R4 -> 0xFFFF
    send_exec(16'h21FF);            // LD R0, #-1 with PC wrapping to 0
    send_exec(16'hA3FE);            // LDI R1, #-2
    send_exec(16'h6A3F);            // LDR R5, R0, #-1 (register contents)
    send_exec(16'h3FFF);            // ST R7, #-1
    send_exec(16'hB300);            // STI R1, #-256
    send_exec(16'h7A1F);            // STR R5, R0, #31
    send_exec(16'h47FF);            // JSR -1
    send_exec(16'h4C00);            // JSR -1024
    send_exec(16'h41C0);            // JSRR R7: target is the old R7
    send_exec(16'hC1C0);            // RET
    send_exec(16'h8000);            // RTI: unsupported
    send_exec(16'hD123);            // reserved opcode
    send_exec(16'hF025);            // TRAP
    wait_drained();

    // --- random phases, one idling pattern each --------------------------------
    run_phase(0, 0, 16'h0000);
    run_phase(51, 0, 16'($urandom));
    run_phase(0, 51, 16'h7FFF);
    run_phase(21, 21, StartPcReset);

    if (n_checked != n_accepted || n_accepted != n_issued) begin
      report_error($sformatf("%0d requests issued, %0d accepted, %0d results",
                             n_issued, n_accepted, n_checked));
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
